@@ src/rra_pkg.sv @@
// Shared types and constants for the rounded rectangle alpha fill block.
// No dependencies; every other file imports this package.
package rra_pkg;

  // Window clip limit; window registers above this are capped to it.
  localparam logic [14:0] COORD_LIM = 15'd4096;

  // Register indexes on the configuration port (word address paddr[4:2])
  localparam logic [2:0] REG_RECT_LEFT     = 3'd0;
  localparam logic [2:0] REG_RECT_TOP      = 3'd1;
  localparam logic [2:0] REG_RECT_WIDTH    = 3'd2;
  localparam logic [2:0] REG_RECT_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_CORNER_RADIUS = 3'd4;
  localparam logic [2:0] REG_FILL_COLOR    = 3'd5;
  localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd6;
  localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd7;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] dest_pixel;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] new_pixel;
  } out_item_t;

  typedef struct packed {
    logic signed [12:0] rect_left;
    logic signed [12:0] rect_top;
    logic [12:0]        rect_width;
    logic [12:0]        rect_height;
    logic [11:0]        corner_radius;
    logic [31:0]        fill_color;
    logic [12:0]        window_width;
    logic [12:0]        window_height;
  } cfg_t;

endpackage

@@ src/rra_cfg.sv @@
// APB-style configuration register file for the rounded rectangle fill.
// Depends on rra_pkg for the register indexes and the cfg_t struct.
module rra_cfg import rra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rect_left     <= '0;
      cfg_r.rect_top      <= '0;
      cfg_r.rect_width    <= '0;
      cfg_r.rect_height   <= '0;
      cfg_r.corner_radius <= '0;
      cfg_r.fill_color    <= '0;
      cfg_r.window_width  <= 13'd380;
      cfg_r.window_height <= 13'd508;
    end else if (wr) begin
      case (idx)
        REG_RECT_LEFT:     cfg_r.rect_left     <= pwdata[12:0];
        REG_RECT_TOP:      cfg_r.rect_top      <= pwdata[12:0];
        REG_RECT_WIDTH:    cfg_r.rect_width    <= pwdata[12:0];
        REG_RECT_HEIGHT:   cfg_r.rect_height   <= pwdata[12:0];
        REG_CORNER_RADIUS: cfg_r.corner_radius <= pwdata[11:0];
        REG_FILL_COLOR:    cfg_r.fill_color    <= pwdata;
        REG_WINDOW_WIDTH:  cfg_r.window_width  <= pwdata[12:0];
        REG_WINDOW_HEIGHT: cfg_r.window_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RECT_LEFT:     prdata = {19'd0, cfg_r.rect_left};
      REG_RECT_TOP:      prdata = {19'd0, cfg_r.rect_top};
      REG_RECT_WIDTH:    prdata = {19'd0, cfg_r.rect_width};
      REG_RECT_HEIGHT:   prdata = {19'd0, cfg_r.rect_height};
      REG_CORNER_RADIUS: prdata = {20'd0, cfg_r.corner_radius};
      REG_FILL_COLOR:    prdata = cfg_r.fill_color;
      REG_WINDOW_WIDTH:  prdata = {19'd0, cfg_r.window_width};
      REG_WINDOW_HEIGHT: prdata = {19'd0, cfg_r.window_height};
      default:           prdata = '0;
    endcase
  end

endmodule

@@ src/rra_cover.sv @@
// Coverage pipeline: window clip, rectangle bounds and rounded corner test.
// Four register stages; depends on rra_pkg for cfg_t and COORD_LIM.
module rra_cover import rra_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  cfg_t        cfg,
  output logic        cov
);

  // stage 1: offsets from the rectangle origin, window clip
  logic signed [15:0] ex_nxt, ey_nxt, ex_r, ey_r;
  logic [14:0]        lim_x, lim_y;
  logic               win_nxt, win_r;

  // stage 2: bounds and corner offsets
  logic signed [15:0] w16, h16, r16, wr16, hr16;
  logic signed [15:0] dxl, dxr, dyt, dyb;
  logic               inrect, left, right, top, bottom;
  logic [11:0]        dx_nxt, dy_nxt, dx_r, dy_r;
  logic               corner_nxt, corner_r, ok_nxt, ok_r;

  // stage 3: squares
  logic [23:0]        dx2_r, dy2_r, rr_r;
  logic               corner3_r, ok3_r;

  // stage 4: distance compare
  logic [24:0]        dsq;
  logic               cov_r;

  always_comb begin
    ex_nxt = $signed({4'd0, pixel_x}) - $signed({{3{cfg.rect_left[12]}}, cfg.rect_left});
    ey_nxt = $signed({4'd0, pixel_y}) - $signed({{3{cfg.rect_top[12]}}, cfg.rect_top});
    lim_x  = ({2'd0, cfg.window_width} < COORD_LIM) ? {2'd0, cfg.window_width} : COORD_LIM;
    lim_y  = ({2'd0, cfg.window_height} < COORD_LIM) ? {2'd0, cfg.window_height} : COORD_LIM;
    win_nxt = ({3'd0, pixel_x} < lim_x) && ({3'd0, pixel_y} < lim_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r  <= ex_nxt;
      ey_r  <= ey_nxt;
      win_r <= win_nxt;
    end
  end

  always_comb begin
    w16  = $signed({3'd0, cfg.rect_width});
    h16  = $signed({3'd0, cfg.rect_height});
    r16  = $signed({4'd0, cfg.corner_radius});
    wr16 = w16 - r16;
    hr16 = h16 - r16;
    inrect = (ex_r >= 16'sd0) && (ex_r < w16) && (ey_r >= 16'sd0) && (ey_r < h16);
    left   = ex_r < r16;
    right  = ex_r >= wr16;
    top    = ey_r < r16;
    bottom = ey_r >= hr16;
    dxl = r16 - ex_r;
    dxr = ex_r - (wr16 - 16'sd1);
    dyt = r16 - ey_r;
    dyb = ey_r - (hr16 - 16'sd1);
    // first matching corner in order TL, TR, BL, BR reduces to this
    corner_nxt = (left || right) && (top || bottom);
    dx_nxt = left ? dxl[11:0] : dxr[11:0];
    dy_nxt = top ? dyt[11:0] : dyb[11:0];
    ok_nxt = win_r && inrect;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      corner_r <= corner_nxt;
      ok_r     <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx2_r     <= 24'(dx_r) * 24'(dx_r);
      dy2_r     <= 24'(dy_r) * 24'(dy_r);
      rr_r      <= 24'(cfg.corner_radius) * 24'(cfg.corner_radius);
      corner3_r <= corner_r;
      ok3_r     <= ok_r;
    end
  end

  assign dsq = {1'b0, dx2_r} + {1'b0, dy2_r};

  always_ff @(posedge clk) begin
    if (en) begin
      cov_r <= ok3_r && (!corner3_r || (dsq <= {1'b0, rr_r}));
    end
  end

  assign cov = cov_r;

endmodule

@@ src/rra_blend.sv @@
// Source-over blend pipeline: alpha products, divide by 255 via reciprocal,
// then a 2-bit-per-stage restoring divide by the output alpha. Uses rra_pkg.
module rra_blend import rra_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] dest_pixel,
  input  cfg_t        cfg,
  output logic [31:0] blend_word,
  output logic [31:0] dest_out
);

  localparam int          LANES    = 3;
  localparam int          DSTAGES  = 4;
  // floor(x * RECIP_255 / 2^32) == floor(x / 255) for all x < 2^24
  localparam logic [24:0] RECIP_255 = 25'h1010102;

  logic [7:0]  sa, inv, da;

  // B1
  logic [15:0] t_r;
  logic [15:0] ssa_r   [LANES];
  logic [7:0]  d_r     [LANES];
  logic [31:0] dest1_r;
  // B2
  logic [40:0] tm;
  logic [7:0]  tq_r;
  logic [23:0] prod_r  [LANES];
  logic [15:0] ssa2_r  [LANES];
  logic [31:0] dest2_r;
  // B3
  logic [8:0]  oa_sum;
  logic [7:0]  oa3_r;
  logic [15:0] pq_r    [LANES];
  logic [15:0] ssa3_r  [LANES];
  logic [31:0] dest3_r;
  // B4
  logic [16:0] num     [LANES];
  logic [16:0] rem4_r  [LANES];
  logic        sat4_r  [LANES];
  logic [7:0]  oa4_r;
  logic [31:0] dest4_r;
  // divide stages
  logic [16:0] rem_r   [DSTAGES][LANES];
  logic [7:0]  q_r     [DSTAGES][LANES];
  logic        sat_r   [DSTAGES][LANES];
  logic [7:0]  oa_r    [DSTAGES];
  logic [31:0] dest_r  [DSTAGES];

  assign sa  = cfg.fill_color[31:24];
  assign inv = 8'd255 - sa;
  assign da  = dest_pixel[31:24];

  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= 16'(da) * 16'(inv);
      dest1_r <= dest_pixel;
      for (int c = 0; c < LANES; c++) begin
        ssa_r[c] <= 16'(cfg.fill_color[8*c +: 8]) * 16'(sa);
        d_r[c]   <= dest_pixel[8*c +: 8];
      end
    end
  end

  assign tm = 41'(t_r) * 41'(RECIP_255);

  always_ff @(posedge clk) begin
    if (en) begin
      tq_r    <= tm[39:32];
      dest2_r <= dest1_r;
      for (int c = 0; c < LANES; c++) begin
        prod_r[c] <= 24'(d_r[c]) * 24'(t_r);
        ssa2_r[c] <= ssa_r[c];
      end
    end
  end

  assign oa_sum = {1'b0, sa} + {1'b0, tq_r};

  always_ff @(posedge clk) begin : b3
    logic [48:0] pm;
    if (en) begin
      oa3_r   <= oa_sum[8] ? 8'd255 : oa_sum[7:0];
      dest3_r <= dest2_r;
      for (int c = 0; c < LANES; c++) begin
        pm = 49'(prod_r[c]) * 49'(RECIP_255);
        pq_r[c]   <= pm[47:32];
        ssa3_r[c] <= ssa2_r[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      num[c] = {1'b0, ssa3_r[c]} + {1'b0, pq_r[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oa4_r   <= oa3_r;
      dest4_r <= dest3_r;
      for (int c = 0; c < LANES; c++) begin
        rem4_r[c] <= num[c];
        // quotient would not fit in 8 bits: channel saturates
        sat4_r[c] <= num[c] >= {1'b0, oa3_r, 8'd0};
      end
    end
  end

  for (genvar k = 0; k < DSTAGES; k++) begin : g_div
    logic [16:0] rem_in [LANES];
    logic [7:0]  q_in   [LANES];
    logic        sat_in [LANES];
    logic [7:0]  oa_in;
    logic [31:0] dest_in;
    logic [16:0] rem_nxt [LANES];
    logic [7:0]  q_nxt   [LANES];

    if (k == 0) begin : g_first
      always_comb begin
        oa_in   = oa4_r;
        dest_in = dest4_r;
        for (int c = 0; c < LANES; c++) begin
          rem_in[c] = rem4_r[c];
          q_in[c]   = '0;
          sat_in[c] = sat4_r[c];
        end
      end
    end else begin : g_next
      always_comb begin
        oa_in   = oa_r[k-1];
        dest_in = dest_r[k-1];
        for (int c = 0; c < LANES; c++) begin
          rem_in[c] = rem_r[k-1][c];
          q_in[c]   = q_r[k-1][c];
          sat_in[c] = sat_r[k-1][c];
        end
      end
    end

    // two restoring steps, quotient bits 7-2k and 6-2k
    always_comb begin
      logic [16:0] rm;
      logic [7:0]  qq;
      logic [16:0] dv;
      for (int c = 0; c < LANES; c++) begin
        rm = rem_in[c];
        qq = q_in[c];
        for (int s = 0; s < 2; s++) begin
          dv = 17'(oa_in) << (7 - 2*k - s);
          if (rm >= dv) begin
            rm = rm - dv;
            qq[7 - 2*k - s] = 1'b1;
          end
        end
        rem_nxt[c] = rm;
        q_nxt[c]   = qq;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        oa_r[k]   <= oa_in;
        dest_r[k] <= dest_in;
        for (int c = 0; c < LANES; c++) begin
          rem_r[k][c] <= rem_nxt[c];
          q_r[k][c]   <= q_nxt[c];
          sat_r[k][c] <= sat_in[c];
        end
      end
    end
  end

  always_comb begin
    blend_word[31:24] = oa_r[DSTAGES-1];
    for (int c = 0; c < LANES; c++) begin
      blend_word[8*c +: 8] = sat_r[DSTAGES-1][c] ? 8'd255 : q_r[DSTAGES-1][c];
    end
  end

  assign dest_out = dest_r[DSTAGES-1];

endmodule

@@ src/rounded_rect_alpha_fill_top.sv @@
// Top level of the rounded rectangle alpha fill: valid pipeline, output stage.
// Instantiates rra_cfg, rra_cover and rra_blend; uses rra_pkg types.
//
//  channel  ports                              direction  beat
//  in       in_valid / in_stall / in_data      input      one pixel + framebuffer word
//  out      out_valid / out_stall / out_data   output     write enable + new word
//  cfg      cfg_psel ... cfg_pready            APB slave  one 32-bit register write/read
//
// One pixel per cycle sustained unless out_stall freezes the pipeline; nine register
// stages. The depth is set by the 8-stage blend path (two reciprocal multiplies,
// 4 divide stages) plus the output register.
// Synchronous active-low reset clears the valid pipeline and resets the config registers (window 380 x 508, rest zero).
// out_stall with out_valid high freezes every stage; in_stall follows it.
module rounded_rect_alpha_fill_top import rra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int COVER_DEPTH = 4;
  localparam int BLEND_DEPTH = 8;
  localparam int STAGES      = BLEND_DEPTH + 1;
  localparam int COV_DLY     = BLEND_DEPTH - COVER_DEPTH;

  cfg_t             cfg;
  logic             en;
  logic [STAGES-1:0] vld_r;
  logic             cov;
  logic             cov_dly_r [COV_DLY];
  logic [31:0]      blend_word, dest_d;
  logic [7:0]       sa;
  out_item_t        out_nxt, out_r;

  rra_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign en       = !(vld_r[STAGES-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  rra_cover u_cover (
    .clk     (clk),
    .en      (en),
    .pixel_x (in_data.pixel_x),
    .pixel_y (in_data.pixel_y),
    .cfg     (cfg),
    .cov     (cov)
  );

  rra_blend u_blend (
    .clk        (clk),
    .en         (en),
    .dest_pixel (in_data.dest_pixel),
    .cfg        (cfg),
    .blend_word (blend_word),
    .dest_out   (dest_d)
  );

  // line the coverage bit up with the blend result
  always_ff @(posedge clk) begin
    if (en) begin
      cov_dly_r[0] <= cov;
      for (int i = 1; i < COV_DLY; i++) begin
        cov_dly_r[i] <= cov_dly_r[i-1];
      end
    end
  end

  assign sa = cfg.fill_color[31:24];

  always_comb begin
    out_nxt.write_enable = cov_dly_r[COV_DLY-1] && (sa != 8'd0);
    if (!out_nxt.write_enable) begin
      out_nxt.new_pixel = dest_d;
    end else if (sa == 8'd255) begin
      out_nxt.new_pixel = cfg.fill_color;
    end else begin
      out_nxt.new_pixel = blend_word;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_data  = out_r;

endmodule
